// ----- sv/kme_pkg.sv -----
`default_nettype none

package kme_pkg;

  localparam int unsigned CodeW   = 10;
  localparam int unsigned ValueW  = 2;
  localparam int unsigned TicksW  = 32;
  localparam int unsigned StepW   = 6;
  localparam int unsigned MoveW   = 8;
  localparam int unsigned NumDirs = 8;
  localparam int unsigned DirW    = 3;

  localparam int unsigned InTdataW  = 48;
  localparam int unsigned OutTdataW = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [StepW-1:0]  StepReset    = 6'd4;
  localparam logic [StepW-1:0]  AccelReset   = 6'd16;
  localparam logic [TicksW-1:0] IdleReset    = 32'd100;
  localparam logic [CodeW-1:0]  ControlReset = 10'd97;
  localparam logic [63:0]       DirReset     = 64'h5150514B4D474849;
  localparam logic [CodeW-1:0]  LeftReset    = 10'd82;
  localparam logic [CodeW-1:0]  RightReset   = 10'd83;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStepSize      = 3'd0,
    CfgMaxAccel      = 3'd1,
    CfgIdleTimeout   = 3'd2,
    CfgControlCode   = 3'd3,
    CfgDirectionCode = 3'd4,
    CfgLeftCode      = 3'd5,
    CfgRightCode     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [StepW-1:0]  step_size;
    logic [StepW-1:0]  accel_limit;
    logic [TicksW-1:0] idle_timeout;
    logic [CodeW-1:0]  control_code;
    logic [63:0]       direction_codes;
    logic [CodeW-1:0]  left_code;
    logic [CodeW-1:0]  right_code;
  } cfg_t;

  // first member is the most significant, so consumed lands in bit 0
  typedef struct packed {
    logic                    report_sync;
    logic                    right_button;
    logic                    right_changed;
    logic                    left_button;
    logic                    left_changed;
    logic signed [MoveW-1:0] move_y;
    logic signed [MoveW-1:0] move_x;
    logic                    move_valid;
    logic                    consumed;
  } res_t;

  // direction order: upleft, up, upright, left, right, downleft, down, downright
  function automatic logic signed [1:0] dir_dx(input logic [DirW-1:0] dir);
    logic signed [1:0] d;
    unique case (dir)
      3'd0, 3'd3, 3'd5: d = -2'sd1;
      3'd1, 3'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [DirW-1:0] dir);
    logic signed [1:0] d;
    unique case (dir)
      3'd0, 3'd1, 3'd2: d = -2'sd1;
      3'd3, 3'd4:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- sv/keypad_mouse_emulator_top.sv -----
// Keypad mouse emulator: turns key events into relative pointer motion and
// button reports while the control key is held. One key event is taken per clock
// while the result register can advance; each gives exactly one result via the
// input register, then the result register. The rate is set by the loop through
// the mode, button, acceleration and last-time registers, so back-to-back events
// run at one per cycle with no bubbles unless the output stalls. Configuration
// registers must be written by the user through the cfg port while idle; unenforced.
`default_nettype none

module keypad_mouse_emulator_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // key_code[9:0], key_value[11:10], now_ticks[43:12], zero fill
  input  wire logic [kme_pkg::InTdataW-1:0]   s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // consumed[0], move_valid[1], move_x[9:2], move_y[17:10], left_changed[18],
  // left_button[19], right_changed[20], right_button[21], report_sync[22], zero fill
  output logic [kme_pkg::OutTdataW-1:0]       m_axis_tdata_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [kme_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [kme_pkg::CfgDataW-1:0]   cfg_data_i
);
  import kme_pkg::*;

  cfg_t              cfg;
  res_t              res;
  logic              in_valid_q;
  logic [CodeW-1:0]  in_code_q;
  logic [ValueW-1:0] in_value_q;
  logic [TicksW-1:0] in_now_q;
  logic              out_valid_q;
  res_t              out_res_q;
  logic              advance;
  logic              s_xfer;
  logic              step_en;

  kme_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kme_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .cfg_i       (cfg),
    .key_code_i  (in_code_q),
    .key_value_i (in_value_q),
    .now_ticks_i (in_now_q),
    .res_o       (res)
  );

  // result register frees up when empty or when its transfer completes
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign step_en         = in_valid_q && advance;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_code_q  <= s_axis_tdata_i[CodeW-1:0];
      in_value_q <= s_axis_tdata_i[CodeW +: ValueW];
      in_now_q   <= s_axis_tdata_i[CodeW+ValueW +: TicksW];
    end
    if (step_en) begin
      out_res_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled while pipeline has room");

  a_move_is_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_res_q.move_valid) |->
      (out_res_q.consumed && !out_res_q.left_changed && !out_res_q.right_changed))
    else $error("motion reported on a key that was not a consumed direction key");

  a_one_button_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(out_res_q.left_changed && out_res_q.right_changed))
    else $error("both buttons reported changed by one event");

  a_result_follows_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> out_valid_q)
    else $error("processed event did not reach the result register");
`endif

endmodule

`default_nettype wire

// ----- sv/kme_cfg_regs.sv -----
`default_nettype none

module kme_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kme_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [kme_pkg::CfgDataW-1:0]  cfg_data_i,
  output kme_pkg::cfg_t                      cfg_o
);
  import kme_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgStepSize:      cfg_d.step_size       = cfg_data_i[StepW-1:0];
        CfgMaxAccel:      cfg_d.accel_limit     = cfg_data_i[StepW-1:0];
        CfgIdleTimeout:   cfg_d.idle_timeout    = cfg_data_i[TicksW-1:0];
        CfgControlCode:   cfg_d.control_code    = cfg_data_i[CodeW-1:0];
        CfgDirectionCode: cfg_d.direction_codes = cfg_data_i[63:0];
        CfgLeftCode:      cfg_d.left_code       = cfg_data_i[CodeW-1:0];
        CfgRightCode:     cfg_d.right_code      = cfg_data_i[CodeW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size       <= StepReset;
      cfg_q.accel_limit     <= AccelReset;
      cfg_q.idle_timeout    <= IdleReset;
      cfg_q.control_code    <= ControlReset;
      cfg_q.direction_codes <= DirReset;
      cfg_q.left_code       <= LeftReset;
      cfg_q.right_code      <= RightReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/kme_step.sv -----
`default_nettype none

module kme_step (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_en_i,
  input  kme_pkg::cfg_t                     cfg_i,
  input  wire logic [kme_pkg::CodeW-1:0]    key_code_i,
  input  wire logic [kme_pkg::ValueW-1:0]   key_value_i,
  input  wire logic [kme_pkg::TicksW-1:0]   now_ticks_i,
  output kme_pkg::res_t                     res_o
);
  import kme_pkg::*;

  logic              held_q, held_d;
  logic [1:0]        button_q, button_d;
  logic [StepW-1:0]  accel_q, accel_d;
  logic [TicksW-1:0] last_q, last_d;

  logic              down;
  logic              dir_hit;
  logic [DirW-1:0]   dir_idx;
  logic              btn_hit;
  logic              btn_sel;
  logic [TicksW-1:0] elapsed;
  logic              idle_hit;
  logic [StepW-1:0]  accel_base;
  logic [StepW:0]    mag;
  logic [StepW:0]    accel_inc;
  logic [StepW-1:0]  accel_clamp;
  logic [MoveW-1:0]  mag_pos;
  logic [MoveW-1:0]  mag_neg;
  logic signed [1:0] dx;
  logic signed [1:0] dy;

  assign down = key_value_i != '0;

  // lowest byte wins when several direction slots hold the same code
  always_comb begin
    dir_hit = 1'b0;
    dir_idx = '0;
    for (int i = NumDirs - 1; i >= 0; i--) begin
      if (key_code_i == {2'b00, cfg_i.direction_codes[8*i +: 8]}) begin
        dir_hit = 1'b1;
        dir_idx = DirW'(i);
      end
    end
  end

  assign btn_sel = key_code_i != cfg_i.left_code;
  assign btn_hit = !dir_hit &&
                   (key_code_i == cfg_i.left_code || key_code_i == cfg_i.right_code);

  assign elapsed    = now_ticks_i - last_q;
  assign idle_hit   = (last_q != '0) && (elapsed >= cfg_i.idle_timeout);
  assign accel_base = idle_hit ? '0 : accel_q;

  assign mag         = {1'b0, cfg_i.step_size} + {1'b0, accel_base};
  assign accel_inc   = {1'b0, accel_base} + 7'd1;
  assign accel_clamp = (accel_inc > {1'b0, cfg_i.accel_limit}) ? cfg_i.accel_limit
                                                                : accel_inc[StepW-1:0];
  assign mag_pos = {1'b0, mag};
  assign mag_neg = -mag_pos;
  assign dx      = dir_dx(dir_idx);
  assign dy      = dir_dy(dir_idx);

  always_comb begin
    held_d   = held_q;
    button_d = button_q;
    accel_d  = accel_q;
    last_d   = last_q;
    res_o    = '0;
    if (key_code_i == cfg_i.control_code) begin
      held_d = down;
    end else if (!held_q) begin
      accel_d  = '0;
      button_d = '0;
    end else if (dir_hit || btn_hit) begin
      res_o.consumed = 1'b1;
      last_d         = now_ticks_i;
      accel_d        = accel_base;
      if (dir_hit && down && mag != '0) begin
        res_o.move_valid = 1'b1;
        res_o.move_x     = (dx < 0) ? mag_neg : ((dx > 0) ? mag_pos : '0);
        res_o.move_y     = (dy < 0) ? mag_neg : ((dy > 0) ? mag_pos : '0);
        accel_d          = accel_clamp;
      end
      if (btn_hit) begin
        // autorepeat of a button already down reports nothing
        if (button_q[btn_sel] != down) begin
          if (btn_sel) begin
            res_o.right_changed = 1'b1;
          end else begin
            res_o.left_changed = 1'b1;
          end
        end
        button_d[btn_sel] = down;
      end
    end
    res_o.left_button  = button_d[0];
    res_o.right_button = button_d[1];
    res_o.report_sync  = res_o.move_valid | res_o.left_changed | res_o.right_changed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 1'b0;
      button_q <= '0;
      accel_q  <= '0;
      last_q   <= '0;
    end else if (step_en_i) begin
      held_q   <= held_d;
      button_q <= button_d;
      accel_q  <= accel_d;
      last_q   <= last_d;
    end
  end

endmodule

`default_nettype wire
